FILE: hw/rtl/lfrng_pkg.sv
// Shared constants, command/status types and reduction helpers of the lagged Fibonacci generator.
`default_nettype none

package lfrng_pkg;

    localparam int LAG_LENGTH    = 97;
    localparam int FRACTION_BITS = 24;

    localparam int SLOT_W = $clog2(LAG_LENGTH);
    localparam int FRAC_W = FRACTION_BITS + 1;
    localparam int CNT_W  = $clog2(FRACTION_BITS);
    localparam int SEED_W = 15;

    localparam logic [SLOT_W-1:0] LONG_START  = SLOT_W'(LAG_LENGTH - 1);
    localparam logic [SLOT_W-1:0] SHORT_START = SLOT_W'(33 - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(LAG_LENGTH - 1);
    localparam logic [CNT_W-1:0]  LAST_BIT    = CNT_W'(FRACTION_BITS - 1);

    localparam logic [FRAC_W-1:0] ONE_FIX = FRAC_W'(1) << FRACTION_BITS;

    localparam logic [FRACTION_BITS-1:0] CARRY_START = FRACTION_BITS'(362436);
    localparam logic [FRACTION_BITS-1:0] CARRY_STEP  = FRACTION_BITS'(7654321);
    localparam logic [FRACTION_BITS-1:0] CARRY_WRAP  = FRACTION_BITS'(16777213 - 7654321);

    localparam logic [SEED_W-1:0] SEED_A_MAX = 15'd31328;
    localparam logic [SEED_W-1:0] SEED_B_MAX = 15'd30081;
    localparam logic [SEED_W-1:0] SEED_A_DEF = 15'd1802;
    localparam logic [SEED_W-1:0] SEED_B_DEF = 15'd9373;

    // Moduli of the seeding generator and their scaled reciprocals (exact for x < 2^15).
    localparam logic [7:0]  MOD_177     = 8'd177;
    localparam logic [7:0]  MOD_169     = 8'd169;
    localparam logic [7:0]  MOD_179     = 8'd179;
    localparam logic [13:0] D_MUL       = 14'd53;
    localparam logic [14:0] RECIP_177   = 15'd23697;
    localparam logic [14:0] RECIP_169   = 15'd24819;
    localparam logic [14:0] RECIP_179   = 15'd23432;
    localparam int          RECIP_SHIFT = 22;

    typedef enum logic {
        KIND_DRAW   = 1'b0,
        KIND_RESEED = 1'b1
    } t_kind;

    typedef enum logic {
        CFG_SEED_FIRST  = 1'b0,
        CFG_SEED_SECOND = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic load_item;
        logic seed_load;
        logic seed_default;
        logic init_quo;
        logic init_rem;
        logic mul_ab;
        logic mul_c;
        logic quo;
        logic rem_ab;
        logic rem_c;
        logic bit_step;
        logic fill_end;
        logic mem_read;
        logic diff;
        logic res;
        logic pp_lo;
        logic pp_hi;
        logic sum;
        logic load_out;
        logic out_zero;
    } t_dp_cmd;

    typedef struct packed {
        logic seeded;
        logic bit_last;
        logic entry_last;
    } t_dp_status;

    function automatic logic [7:0] recip_quot(input logic [14:0] x, input logic [14:0] k);
        logic [29:0] p;
        p = x * k;
        return p[RECIP_SHIFT +: 8];
    endfunction

    function automatic logic [7:0] recip_rem(input logic [14:0] x, input logic [7:0] q,
                                             input logic [7:0] d);
        logic [15:0] p;
        logic [14:0] r;
        p = q * d;
        r = x - p[14:0];
        return r[7:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lfrng_dp.sv
// Datapath of the lagged Fibonacci generator: seed registers, lag table, seeding and draw arithmetic.
`default_nettype none

module lfrng_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_index,
    input  logic [lfrng_pkg::SEED_W-1:0]       i_cfg_data,
    input  logic signed [31:0]                 i_range_low,
    input  logic signed [31:0]                 i_range_high,
    input  lfrng_pkg::t_dp_cmd                 i_cmd,
    output lfrng_pkg::t_dp_status              o_status,
    output logic [lfrng_pkg::FRAC_W-1:0]       o_fraction,
    output logic signed [31:0]                 o_value,
    output logic                               o_bad
);
    import lfrng_pkg::*;

    logic [SEED_W-1:0]        r_seed_first;
    logic [SEED_W-1:0]        r_seed_second;
    logic [SEED_W-1:0]        r_sa;
    logic [SEED_W-1:0]        r_sb;
    logic [7:0]               r_qa;
    logic [7:0]               r_qb;
    logic [7:0]               r_a;
    logic [7:0]               r_b;
    logic [7:0]               r_c;
    logic [7:0]               r_d;
    logic [14:0]              r_prod;
    logic [13:0]              r_dprod;
    logic [7:0]               r_quo;
    logic [5:0]               r_dquo;
    logic [FRACTION_BITS-1:0] r_acc;
    logic [CNT_W-1:0]         r_bit_cnt;
    logic [SLOT_W-1:0]        r_entry;
    logic [SLOT_W-1:0]        r_long;
    logic [SLOT_W-1:0]        r_short;
    logic [FRACTION_BITS-1:0] r_carry;
    logic                     r_seeded;

    logic signed [31:0]       r_low;
    logic signed [31:0]       r_high;
    logic [FRAC_W-1:0]        r_x;
    logic [FRAC_W-1:0]        r_y;
    logic [FRAC_W-1:0]        r_uni;
    logic [FRAC_W-1:0]        r_res;
    logic [32:0]              r_span;
    logic                     r_bad;
    logic [40:0]              r_pp_lo;
    logic [41:0]              r_pp_hi;
    logic [31:0]              r_q;
    logic [FRAC_W-1:0]        r_lag_table [LAG_LENGTH];

    logic                     w_seed_bad;
    logic [SEED_W-1:0]        w_sa_eff;
    logic [SEED_W-1:0]        w_sb_eff;
    logic [7:0]               w_mul_l;
    logic [7:0]               w_mul_r;
    logic [15:0]              w_mul;
    logic [13:0]              w_dlin;
    logic [7:0]               w_rem;
    logic [15:0]              w_dm;
    logic [FRACTION_BITS-1:0] w_acc_next;
    logic [FRAC_W-1:0]        w_uni;
    logic [FRAC_W-1:0]        w_res;
    logic [32:0]              w_span;
    logic [16:0]              w_pp_opd;
    logic [41:0]              w_pp;
    logic [57:0]              w_sum;
    logic                     w_wr_en;
    logic [SLOT_W-1:0]        w_wr_addr;
    logic [FRAC_W-1:0]        w_wr_data;

    // Out-of-range seeds fall back to the default pair; so does the implicit first seeding.
    assign w_seed_bad = i_cmd.seed_default || (r_seed_first > SEED_A_MAX)
                        || (r_seed_second > SEED_B_MAX);
    assign w_sa_eff   = w_seed_bad ? SEED_A_DEF : r_seed_first;
    assign w_sb_eff   = w_seed_bad ? SEED_B_DEF : r_seed_second;

    // One shared 8x8 multiplier serves a*b and (a*b mod 179)*c.
    assign w_mul_l    = i_cmd.mul_ab ? r_a : r_prod[7:0];
    assign w_mul_r    = i_cmd.mul_ab ? r_b : r_c;
    assign w_mul      = w_mul_l * w_mul_r;
    assign w_dlin     = D_MUL * {6'b0, r_d} + 14'd1;
    assign w_rem      = recip_rem(r_prod, r_quo, MOD_179);
    assign w_dm       = r_d * r_c;
    assign w_acc_next = {r_acc[FRACTION_BITS-2:0], w_dm[5]};

    assign w_uni = (r_x > r_y) ? (r_x - r_y) : (ONE_FIX - (r_y - r_x));
    assign w_res = (r_uni >= {1'b0, r_carry}) ? (r_uni - {1'b0, r_carry})
                                              : (r_uni + ONE_FIX - {1'b0, r_carry});
    assign w_span = {r_high[31], r_high} - {r_low[31], r_low} + 33'd1;

    // Span product in two partial products through one 25x17 multiplier.
    assign w_pp_opd = i_cmd.pp_hi ? r_span[32:16] : {1'b0, r_span[15:0]};
    assign w_pp     = r_res * w_pp_opd;
    assign w_sum    = {r_pp_hi, 16'b0} + {17'b0, r_pp_lo};

    assign w_wr_en   = (i_cmd.bit_step && (r_bit_cnt == LAST_BIT)) || i_cmd.diff;
    assign w_wr_addr = i_cmd.diff ? r_long : r_entry;
    assign w_wr_data = i_cmd.diff ? w_uni : {1'b0, w_acc_next};

    assign o_status.seeded     = r_seeded;
    assign o_status.bit_last   = (r_bit_cnt == LAST_BIT);
    assign o_status.entry_last = (r_entry == LAST_SLOT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_first  <= SEED_A_DEF;
            r_seed_second <= SEED_B_DEF;
            r_bit_cnt     <= '0;
            r_entry       <= '0;
            r_long        <= LONG_START;
            r_short       <= SHORT_START;
            r_carry       <= CARRY_START;
            r_seeded      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_SEED_FIRST:  r_seed_first  <= i_cfg_data;
                    CFG_SEED_SECOND: r_seed_second <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.init_rem) begin
                r_bit_cnt <= '0;
                r_entry   <= '0;
            end
            if (i_cmd.bit_step) begin
                if (r_bit_cnt == LAST_BIT) begin
                    r_bit_cnt <= '0;
                    r_entry   <= r_entry + 1'b1;
                end else begin
                    r_bit_cnt <= r_bit_cnt + 1'b1;
                end
            end
            if (i_cmd.fill_end) begin
                r_long   <= LONG_START;
                r_short  <= SHORT_START;
                r_carry  <= CARRY_START;
                r_seeded <= 1'b1;
            end
            if (i_cmd.diff) begin
                r_long  <= (r_long == '0) ? LAST_SLOT : r_long - 1'b1;
                r_short <= (r_short == '0) ? LAST_SLOT : r_short - 1'b1;
                r_carry <= (r_carry >= CARRY_STEP) ? (r_carry - CARRY_STEP)
                                                   : (r_carry + CARRY_WRAP);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_low  <= i_range_low;
            r_high <= i_range_high;
        end
        if (i_cmd.seed_load) begin
            r_sa <= w_sa_eff;
            r_sb <= w_sb_eff;
        end
        if (i_cmd.init_quo) begin
            r_qa <= recip_quot(r_sa, RECIP_177);
            r_qb <= recip_quot(r_sb, RECIP_169);
        end
        if (i_cmd.init_rem) begin
            r_a <= r_qa + 8'd2;
            r_b <= recip_rem(r_sa, r_qa, MOD_177) + 8'd2;
            r_c <= r_qb + 8'd1;
            r_d <= recip_rem(r_sb, r_qb, MOD_169);
        end
        if (i_cmd.mul_ab) begin
            r_prod  <= w_mul[14:0];
            r_dprod <= w_dlin;
        end
        if (i_cmd.mul_c) begin
            r_prod <= w_mul[14:0];
        end
        if (i_cmd.quo) begin
            r_quo  <= recip_quot(r_prod, RECIP_179);
            r_dquo <= 6'(recip_quot({1'b0, r_dprod}, RECIP_169));
        end
        if (i_cmd.rem_ab) begin
            r_prod <= {7'b0, w_rem};
            r_d    <= recip_rem({1'b0, r_dprod}, {2'b0, r_dquo}, MOD_169);
        end
        if (i_cmd.rem_c) begin
            r_a <= r_b;
            r_b <= r_c;
            r_c <= w_rem;
        end
        if (i_cmd.bit_step) begin
            r_acc <= w_acc_next;
        end
        if (i_cmd.diff) begin
            r_uni <= w_uni;
        end
        if (i_cmd.res) begin
            r_res  <= w_res;
            r_span <= w_span;
            r_bad  <= (r_high < r_low);
        end
        if (i_cmd.pp_lo) begin
            r_pp_lo <= w_pp[40:0];
        end
        if (i_cmd.pp_hi) begin
            r_pp_hi <= w_pp;
        end
        if (i_cmd.sum) begin
            r_q <= w_sum[FRACTION_BITS +: 32];
        end
        if (i_cmd.load_out) begin
            if (i_cmd.out_zero) begin
                o_fraction <= '0;
                o_value    <= '0;
                o_bad      <= 1'b0;
            end else begin
                o_fraction <= r_res;
                o_value    <= r_bad ? r_low : (r_low + $signed(r_q));
                o_bad      <= r_bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_lag_table[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.mem_read) begin
            r_x <= r_lag_table[r_long];
            r_y <= r_lag_table[r_short];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lfrng_ctrl.sv
// Controller of the lagged Fibonacci generator: sequences seeding, draws and the result handshake.
`default_nettype none

module lfrng_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_in_kind,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  lfrng_pkg::t_dp_status i_status,
    output lfrng_pkg::t_dp_cmd    o_cmd
);
    import lfrng_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE     = 19'h00001,
        S_SEED     = 19'h00002,
        S_INIT_Q   = 19'h00004,
        S_INIT_R   = 19'h00008,
        S_MUL_AB   = 19'h00010,
        S_QUO_AB   = 19'h00020,
        S_REM_AB   = 19'h00040,
        S_MUL_C    = 19'h00080,
        S_QUO_C    = 19'h00100,
        S_REM_C    = 19'h00200,
        S_BIT      = 19'h00400,
        S_FILL_END = 19'h00800,
        S_READ     = 19'h01000,
        S_DIFF     = 19'h02000,
        S_RES      = 19'h04000,
        S_PP_LO    = 19'h08000,
        S_PP_HI    = 19'h10000,
        S_SUM      = 19'h20000,
        S_DONE     = 19'h40000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_kind  r_kind;
    t_kind  n_kind;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind = t_kind'(i_in_kind);
                    if (t_kind'(i_in_kind) == KIND_RESEED || !i_status.seeded) begin
                        n_state = S_SEED;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_SEED:     n_state = S_INIT_Q;
            S_INIT_Q:   n_state = S_INIT_R;
            S_INIT_R:   n_state = S_MUL_AB;
            S_MUL_AB:   n_state = S_QUO_AB;
            S_QUO_AB:   n_state = S_REM_AB;
            S_REM_AB:   n_state = S_MUL_C;
            S_MUL_C:    n_state = S_QUO_C;
            S_QUO_C:    n_state = S_REM_C;
            S_REM_C:    n_state = S_BIT;
            S_BIT: begin
                if (i_status.bit_last && i_status.entry_last) begin
                    n_state = S_FILL_END;
                end else begin
                    n_state = S_MUL_AB;
                end
            end
            S_FILL_END: n_state = (r_kind == KIND_RESEED) ? S_DONE : S_READ;
            S_READ:     n_state = S_DIFF;
            S_DIFF:     n_state = S_RES;
            S_RES:      n_state = S_PP_LO;
            S_PP_LO:    n_state = S_PP_HI;
            S_PP_HI:    n_state = S_SUM;
            S_SUM:      n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd              = '0;
        o_cmd.load_item    = w_accept;
        o_cmd.seed_load    = (r_state == S_SEED);
        o_cmd.seed_default = (r_kind == KIND_DRAW);
        o_cmd.init_quo     = (r_state == S_INIT_Q);
        o_cmd.init_rem     = (r_state == S_INIT_R);
        o_cmd.mul_ab       = (r_state == S_MUL_AB);
        o_cmd.mul_c        = (r_state == S_MUL_C);
        o_cmd.quo          = (r_state == S_QUO_AB) || (r_state == S_QUO_C);
        o_cmd.rem_ab       = (r_state == S_REM_AB);
        o_cmd.rem_c        = (r_state == S_REM_C);
        o_cmd.bit_step     = (r_state == S_BIT);
        o_cmd.fill_end     = (r_state == S_FILL_END);
        o_cmd.mem_read     = (r_state == S_READ);
        o_cmd.diff         = (r_state == S_DIFF);
        o_cmd.res          = (r_state == S_RES);
        o_cmd.pp_lo        = (r_state == S_PP_LO);
        o_cmd.pp_hi        = (r_state == S_PP_HI);
        o_cmd.sum          = (r_state == S_SUM);
        o_cmd.load_out     = (r_state == S_DONE) && w_out_free;
        o_cmd.out_zero     = (r_kind == KIND_RESEED);
    end

    // Hold the result until taken; a new load replaces a result taken in the same cycle.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= KIND_DRAW;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lagged_fibonacci_uniform_rng_unit.sv
// Top level of the lagged Fibonacci (97/33 subtractive) uniform random number unit.
`default_nettype none

// Subtractive lagged Fibonacci generator with a 97-entry lag table and a carry
// sequence mod 16777213, all in exact 24-bit fixed point. Each input
// transaction gives exactly one output transaction. A draw (tuser 0) returns
// the 25-bit fraction (2^24 means exactly one) and floor(fraction * span / 2^24)
// plus range_low; with range_high below range_low the flag in m_axis_tuser is
// set and range_low is returned, while the generator still advances. A reseed
// (tuser 1) refills the table from the two seed registers, or from 1802/9373
// when either seed is out of range, and returns an all-zero transaction. A
// draw arriving before any reseed first seeds from 1802/9373. Items are worked
// one at a time: a draw steps through the lag-table read, the subtract and
// carry update, the result, two partial products and the sum around the
// single lag-table memory, and the next item is taken only after its result
// is loaded. A reseed refills the table bit by bit: every one of the 2328
// table bits costs seven steps of one shared 8x8 multiplier and a reciprocal
// mod-179 reduction. s_axis_tready is high only while idle; it does not wait
// for a pending result to be taken. Seed writes are taken at any time but
// belong to idle periods.
module lagged_fibonacci_uniform_rng_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] range_low, [63:32] range_high
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [24:0] uniform_fraction, [56:25] ranged_value, zero pad
    output logic        m_axis_tuser,   // [0] range_bad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [14:0] i_cfg_data
);
    import lfrng_pkg::*;

    t_dp_cmd            w_cmd;
    t_dp_status         w_status;
    logic [FRAC_W-1:0]  w_fraction;
    logic signed [31:0] w_value;
    logic               w_bad;

    // Seed registers accept a write in any cycle.
    assign o_cfg_ready = 1'b1;

    lfrng_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_kind   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    lfrng_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_range_low  (s_axis_tdata[31:0]),
        .i_range_high (s_axis_tdata[63:32]),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_fraction   (w_fraction),
        .o_value      (w_value),
        .o_bad        (w_bad)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = {7'b0, w_value, w_fraction};
    assign m_axis_tuser = w_bad;

    // Work on one item at a time: drop ready right after a transaction.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in progress");

    // The fraction never exceeds one.
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[FRAC_W-1:0] <= ONE_FIX))
        else $error("uniform fraction above one");

    // The lag table is read only after it has been filled.
    a_read_seeded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mem_read |-> w_status.seeded)
        else $error("lag table read before seeding");

    // A new result never overwrites one still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten before transfer");

endmodule

`default_nettype wire

FILE: tb/sv/tb_lagged_fibonacci_uniform_rng_unit.sv
// Self-checking testbench of the lagged Fibonacci uniform random number unit.
`default_nettype none

module tb_lagged_fibonacci_uniform_rng_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import lfrng_pkg::*;

    // Lag offsets of the subtractive scheme, as zero-based table slots.
    localparam int unsigned SHORT_SLOT_START = 32;
    localparam int unsigned LONG_SLOT_START  = LAG_LENGTH - 1;

    localparam logic [31:0] I32_MIN   = 32'h8000_0000;
    localparam logic [31:0] I32_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] I32_ONES  = 32'hFFFF_FFFF;
    localparam longint      I32_MAX_L = 64'sd2147483647;
    localparam longint      I32_MIN_L = -64'sd2147483648;

    // A reseed walks the whole lag table; the run has under twenty of them
    // plus a few hundred draws, so this is several times the slowest run.
    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    typedef struct {
        logic [24:0] fraction;
        logic [31:0] ranged;
        logic        bad;
    } t_draw_result;

    // Holds a private copy of the generator state and the seed registers,
    // computes the result of each accepted item and checks the outputs
    // against them in order.
    class lf_rng_board;
        logic [14:0]  seed_a;
        logic [14:0]  seed_b;
        logic [24:0]  lag_mem [LAG_LENGTH];
        int unsigned  long_slot;
        int unsigned  short_slot;
        logic [23:0]  carry;
        bit           seeded;
        t_draw_result expected_q [$];
        int           mismatches;
        int           draws_seen;
        int           reseeds_seen;
        int           inverted_seen;
        int           results_seen;

        function new();
            seed_a = SEED_A_DEF;
            seed_b = SEED_B_DEF;
            foreach (lag_mem[e]) lag_mem[e] = '0;
            long_slot  = LONG_SLOT_START;
            short_slot = SHORT_SLOT_START;
            carry      = CARRY_START;
            seeded     = 1'b0;
            mismatches = 0;
            draws_seen = 0;
            reseeds_seen  = 0;
            inverted_seen = 0;
            results_seen  = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_seed(t_cfg_index idx, logic [14:0] value);
            case (idx)
                CFG_SEED_FIRST:  seed_a = value;
                CFG_SEED_SECOND: seed_b = value;
                default:         seed_a = seed_a;
            endcase
        endfunction

        // Fill the lag table with the three-lag multiplicative / linear
        // congruential bit generator, 24 bits per entry, MSB first.
        function void fill_lags(int unsigned sa, int unsigned sb);
            int unsigned a, b, c, d, m, acc;
            if (sa > SEED_A_MAX || sb > SEED_B_MAX) begin
                sa = SEED_A_DEF;
                sb = SEED_B_DEF;
            end
            a = (sa / 177) % 177 + 2;
            b = (sa % 177) + 2;
            c = (sb / 169) % 178 + 1;
            d = sb % 169;
            for (int e = 0; e < LAG_LENGTH; e++) begin
                acc = 0;
                for (int bit_n = 0; bit_n < FRACTION_BITS; bit_n++) begin
                    m = (((a * b) % 179) * c) % 179;
                    a = b;
                    b = c;
                    c = m;
                    d = (53 * d + 1) % 169;
                    acc = (acc << 1) | (((d * m) % 64) >= 32 ? 1 : 0);
                end
                lag_mem[e] = 25'(acc);
            end
            long_slot  = LONG_SLOT_START;
            short_slot = SHORT_SLOT_START;
            carry      = CARRY_START;
            seeded     = 1'b1;
        endfunction

        function void take_item(t_kind kind, logic [31:0] lo_bits, logic [31:0] hi_bits);
            logic [24:0]       x, y, uni, res;
            longint            lo, hi, span;
            longint unsigned   q;
            t_draw_result      r;
            if (kind == KIND_RESEED) begin
                fill_lags(seed_a, seed_b);
                r.fraction = '0;
                r.ranged   = '0;
                r.bad      = 1'b0;
                reseeds_seen++;
                expected_q.push_back(r);
                return;
            end
            // A draw ahead of any reseed ignores the registers.
            if (!seeded) fill_lags(SEED_A_DEF, SEED_B_DEF);

            x = lag_mem[long_slot];
            y = lag_mem[short_slot];
            // Wrap a non-positive difference by one; equal entries give one.
            if (x > y) uni = x - y;
            else       uni = ONE_FIX - (y - x);
            lag_mem[long_slot] = uni;
            long_slot  = (long_slot == 0)  ? LAG_LENGTH - 1 : long_slot - 1;
            short_slot = (short_slot == 0) ? LAG_LENGTH - 1 : short_slot - 1;

            if (carry >= CARRY_STEP) carry = carry - CARRY_STEP;
            else                     carry = carry + CARRY_WRAP;

            if (uni >= {1'b0, carry}) res = uni - {1'b0, carry};
            else                      res = uni + ONE_FIX - {1'b0, carry};

            lo = longint'($signed(lo_bits));
            hi = longint'($signed(hi_bits));
            r.fraction = res;
            draws_seen++;
            if (hi < lo) begin
                r.ranged = lo_bits;
                r.bad    = 1'b1;
                inverted_seen++;
            end else begin
                span     = hi - lo + 1;
                q        = (longint'(res) * span) >> FRACTION_BITS;
                r.ranged = lo_bits + 32'(q);
                r.bad    = 1'b0;
            end
            expected_q.push_back(r);
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("[%0t] MISMATCH %0d: %s", $realtime, mismatches, msg);
        endtask

        task match_output(logic [63:0] data, logic user);
            t_draw_result want;
            if (expected_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected result tdata=%h tuser=%b", data, user));
                return;
            end
            want = expected_q.pop_front();
            results_seen++;
            if (data[24:0] !== want.fraction)
                flag_mismatch($sformatf("result %0d fraction %h, want %h",
                                        results_seen, data[24:0], want.fraction));
            if (data[56:25] !== want.ranged)
                flag_mismatch($sformatf("result %0d ranged value %h, want %h",
                                        results_seen, data[56:25], want.ranged));
            if (data[63:57] !== '0)
                flag_mismatch($sformatf("result %0d pad bits %h not zero",
                                        results_seen, data[63:57]));
            if (user !== want.bad)
                flag_mismatch($sformatf("result %0d range flag %b, want %b",
                                        results_seen, user, want.bad));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [31:0] range_low, [63:32] range_high
    logic        s_axis_tuser;   // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [24:0] uniform_fraction, [56:25] ranged_value, zero pad
    logic        m_axis_tuser;   // [0] range_bad
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [14:0] i_cfg_data;

    lf_rng_board sb;
    bit          steady;          // while set, neither side idles
    int          settings_used;
    int unsigned cycle_count;

    lagged_fibonacci_uniform_rng_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one input transaction and hold it until the block takes it.
    // Called at a clock edge; returns at the edge of acceptance, with valid
    // still high so a back-to-back item needs no extra assignment.
    task automatic push_item(t_kind kind, logic [31:0] lo, logic [31:0] hi);
        int unsigned gap;
        gap = gap_len();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hi, lo};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop valid and wait until every expected result is back, then let
    // the block settle. First step past the current edge so the monitor
    // has logged the last accepted item.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // Write both seed registers back to back; only call while idle.
    task automatic write_seeds(logic [14:0] a, logic [14:0] b);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SEED_FIRST;
        i_cfg_data  <= a;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_SEED_SECOND;
        i_cfg_data  <= b;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Receiver: hold tready high for a random stretch, then stall at random.
    initial begin
        int unsigned hold, gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            m_axis_tready <= 1'b1;
            hold = steady ? 1 : $urandom_range(1, 12);
            repeat (hold) @(posedge i_clk);
            gap = gap_len();
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Monitor: sample every handshake on the pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_seed(t_cfg_index'(i_cfg_index), i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.take_item(t_kind'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[63:32]);
            if (m_axis_tvalid && m_axis_tready)
                sb.match_output(m_axis_tdata, m_axis_tuser);
        end
    end

    // Watchdog: end the run if it is stuck.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.pending());
        $display("tb_lagged_fibonacci_uniform_rng_unit: done, errors");
        $finish;
    end

    initial begin
        longint      lo_l, hi_l;
        logic [31:0] lo, hi;
        logic [14:0] sa, sb_seed;

        sb            = new();
        steady        = 1'b0;
        settings_used = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = 1'b0;
        i_cfg_data    = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Load non-default seeds first: the draw ahead of any reseed must
        // still seed from the fixed defaults, and the reseed after it from 0/0.
        write_seeds('0, '0);
        push_item(KIND_DRAW, 32'd0, 32'd99);
        push_item(KIND_RESEED, I32_ONES, I32_ONES);
        // Range extremes: full span, single values, both ends of the 32-bit
        // range, and inverted ranges including the widest one.
        push_item(KIND_DRAW, I32_MIN, I32_MAX);
        push_item(KIND_DRAW, 32'd5, 32'd5);
        push_item(KIND_DRAW, 32'd10, 32'd3);
        push_item(KIND_DRAW, I32_MAX, I32_MAX);
        push_item(KIND_DRAW, I32_MIN, I32_MIN);
        push_item(KIND_DRAW, I32_MAX, I32_MIN);
        push_item(KIND_DRAW, I32_ONES, I32_ONES);
        push_item(KIND_DRAW, I32_MIN, I32_ONES);
        push_item(KIND_DRAW, 32'd0, I32_MAX);
        drain();

        // Largest valid seeds.
        write_seeds(SEED_A_MAX, SEED_B_MAX);
        push_item(KIND_RESEED, 32'd0, 32'd0);
        push_item(KIND_DRAW, 32'd0, 32'd1000);
        push_item(KIND_DRAW, -32'sd1000, 32'd0);
        drain();

        // First seed one past its range: both fall back to the defaults.
        write_seeds(SEED_A_MAX + 15'd1, SEED_B_MAX);
        push_item(KIND_RESEED, 32'd0, 32'd0);
        push_item(KIND_DRAW, 32'd0, 32'd99);
        drain();

        // Both seeds at the register maximum.
        write_seeds('1, '1);
        push_item(KIND_RESEED, 32'd0, 32'd0);
        push_item(KIND_DRAW, I32_MIN, I32_MAX);
        drain();

        // Second seed one past its range.
        write_seeds('0, SEED_B_MAX + 15'd1);
        push_item(KIND_RESEED, 32'd0, 32'd0);
        push_item(KIND_DRAW, 32'd0, 32'd255);

        // Random phases: new seeds, a reseed, then a run of draws with an
        // occasional extra reseed. Every third phase runs without idling.
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            steady = (ph % 3 == 1);
            if ($urandom_range(0, 9) < 7) begin
                sa      = 15'($urandom_range(0, SEED_A_MAX));
                sb_seed = 15'($urandom_range(0, SEED_B_MAX));
            end else begin
                sa      = 15'($urandom_range(0, 32767));
                sb_seed = 15'($urandom_range(0, 32767));
            end
            write_seeds(sa, sb_seed);
            push_item(KIND_RESEED, $urandom, $urandom);
            for (int k = 0; k < 56; k++) begin
                if ($urandom_range(0, 99) == 0) begin
                    push_item(KIND_RESEED, $urandom, $urandom);
                end else begin
                    case ($urandom_range(0, 7))
                        0, 1: begin
                            lo_l = $signed($urandom);
                            hi_l = $signed($urandom);
                        end
                        2: begin
                            lo_l = $signed($urandom);
                            hi_l = lo_l + longint'($urandom_range(0, 255));
                        end
                        3: begin
                            lo_l = longint'($urandom_range(0, 200)) - 100;
                            hi_l = lo_l + longint'($urandom_range(0, 1000));
                        end
                        4: begin
                            lo_l = I32_MIN_L;
                            hi_l = $signed($urandom);
                        end
                        5: begin
                            lo_l = $signed($urandom);
                            hi_l = I32_MAX_L;
                        end
                        6: begin
                            lo_l = $signed($urandom);
                            hi_l = lo_l;
                        end
                        default: begin
                            lo_l = $signed($urandom);
                            hi_l = lo_l - longint'($urandom_range(1, 100));
                        end
                    endcase
                    // Clamp to the 32-bit signed range.
                    if (hi_l > I32_MAX_L) hi_l = I32_MAX_L;
                    if (hi_l < I32_MIN_L) hi_l = I32_MIN_L;
                    lo = lo_l[31:0];
                    hi = hi_l[31:0];
                    push_item(KIND_DRAW, lo, hi);
                end
            end
        end
        steady = 1'b0;
        drain();

        while (sb.pending() != 0) begin
            void'(sb.expected_q.pop_front());
            sb.flag_mismatch("expected result never arrived");
        end

        $display("covered %0d draws (%0d with an inverted range) and %0d table reseeds",
                 sb.draws_seen, sb.inverted_seen, sb.reseeds_seen);
        $display("across %0d seed settings; %0d results compared, %0d mismatches",
                 settings_used, sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("tb_lagged_fibonacci_uniform_rng_unit: done, clean");
        end else begin
            $display("tb_lagged_fibonacci_uniform_rng_unit: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
